@@ hw/rtl/b32e_pkg.sv @@
// Shared types and constants for the base32 stream encoder.
// Holds the job record passed from front to back and the alphabet lookup.
// No dependencies.
`default_nettype none

package b32e_pkg;

    // Character code widths
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned GROUP_W = 5;

    // Padding character '='
    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;

    // One classified item: up to three group indices plus a run of pads
    typedef struct packed {
        logic [GROUP_W-1:0] idx0;
        logic [GROUP_W-1:0] idx1;
        logic [GROUP_W-1:0] idx2;
        logic [1:0]         ncode;   // group characters, 0..3
        logic [2:0]         npad;    // pad characters, 0..7
        logic               is_end;  // job closes the message
    } job_t;

    // RFC 4648 alphabet: A-Z then 2-7
    function automatic logic [CHAR_W-1:0] alpha_char(input logic [GROUP_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        if (idx < 5'd26)
        begin
            c = 7'd65 + {2'b00, idx};
        end
        else
        begin
            c = 7'd50 + {2'b00, idx - 5'd26};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/b32e_front.sv @@
// Front end of the base32 encoder: takes input beats, tracks leftover bits
// and the character count, and turns each beat into a job record.
// Depends on b32e_pkg.
`default_nettype none

module b32e_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        data_byte,
    input  wire logic              has_byte,
    input  wire logic              end_of_message,
    output b32e_pkg::job_t         job,
    output logic                   job_push
);
    import b32e_pkg::*;

    logic [3:0]  bits_reg, bits_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [2:0]  cm_reg, cm_next;

    logic [11:0] cur_bits;
    logic [3:0]  cur_cnt;
    logic [1:0]  k;
    logic [3:0]  rem_wide;
    logic [2:0]  rem_cnt;
    logic [3:0]  rem_bits;
    logic [8:0]  flush_wide;
    logic [4:0]  g0, g1, gf;
    logic        flush;
    logic [1:0]  ncode;
    logic [2:0]  cm_sum;
    logic [2:0]  npad;

    // Append the byte to the leftover bits and count the complete groups
    always_comb
    begin
        if (has_byte)
        begin
            cur_bits = {bits_reg, data_byte};
            cur_cnt  = {1'b0, cnt_reg} + 4'd8;
        end
        else
        begin
            cur_bits = {8'd0, bits_reg};
            cur_cnt  = {1'b0, cnt_reg};
        end

        if (!has_byte)
        begin
            k = 2'd0;
        end
        else if (cur_cnt >= 4'd10)
        begin
            k = 2'd2;
        end
        else
        begin
            k = 2'd1;
        end

        unique case (k)
            2'd2:    rem_wide = cur_cnt - 4'd10;
            2'd1:    rem_wide = cur_cnt - 4'd5;
            default: rem_wide = cur_cnt;
        endcase
        rem_cnt  = rem_wide[2:0];
        rem_bits = 4'(cur_bits & ((12'd1 << rem_cnt) - 12'd1));

        // Group indices, most significant first
        g0 = 5'(cur_bits >> (cur_cnt - 4'd5));
        g1 = (k == 2'd2) ? 5'(cur_bits >> (cur_cnt - 4'd10)) : 5'd0;

        // Partial group padded on the right with zero bits
        flush_wide = {5'd0, rem_bits} << (3'd5 - rem_cnt);
        gf         = flush_wide[4:0];
        flush      = end_of_message && (rem_cnt != 3'd0);

        ncode  = k + {1'b0, flush};
        cm_sum = cm_reg + {1'b0, ncode};
        npad   = end_of_message ? (3'd0 - cm_sum) : 3'd0;

        job.idx0   = (k == 2'd0) ? gf : g0;
        job.idx1   = (k == 2'd1) ? gf : g1;
        job.idx2   = gf;
        job.ncode  = ncode;
        job.npad   = npad;
        job.is_end = end_of_message;

        job_push = accept && ((ncode != 2'd0) || (npad != 3'd0));

        // State update; end of message clears everything
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        cm_next   = cm_reg;
        if (accept)
        begin
            if (end_of_message)
            begin
                bits_next = 4'd0;
                cnt_next  = 3'd0;
                cm_next   = 3'd0;
            end
            else
            begin
                bits_next = rem_bits;
                cnt_next  = rem_cnt;
                cm_next   = cm_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= 4'd0;
            cnt_reg  <= 3'd0;
            cm_reg   <= 3'd0;
        end
        else
        begin
            bits_reg <= bits_next;
            cnt_reg  <= cnt_next;
            cm_reg   <= cm_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/b32e_fifo.sv @@
// Small job queue between the encoder's front and back ends.
// Depends on b32e_pkg for the job record.
`default_nettype none

module b32e_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire b32e_pkg::job_t wr_job,
    input  wire logic           pop,
    output b32e_pkg::job_t      rd_job,
    output logic                full,
    output logic                empty
);
    import b32e_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = slot_reg[rd_ptr_reg];

    // Pointer and fill count bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/b32e_back.sv @@
// Back end of the base32 encoder: steps through a job one character per cycle
// while char_ready allows, into a registered output beat. Depends on b32e_pkg.
`default_nettype none

module b32e_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire b32e_pkg::job_t              job,
    input  wire logic                        job_avail,
    output logic                             job_pop,
    output logic                             char_valid,
    input  wire logic                        char_ready,
    output logic [b32e_pkg::CHAR_W-1:0]      code_char,
    output logic                             last_char
);
    import b32e_pkg::*;

    logic [3:0]        step_reg, step_next;
    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;

    logic [3:0]        total;
    logic              final_step;
    logic              load;
    logic [GROUP_W-1:0] idx;

    // Pick the character for the current step of the head job
    always_comb
    begin
        total      = {2'd0, job.ncode} + {1'b0, job.npad};
        final_step = (step_reg == total - 4'd1);
        load       = job_avail && (!valid_reg || char_ready);
        job_pop    = load && final_step;

        unique case (step_reg[1:0])
            2'd0:    idx = job.idx0;
            2'd1:    idx = job.idx1;
            default: idx = job.idx2;
        endcase

        step_next  = step_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;

        if (valid_reg && char_ready)
        begin
            valid_next = 1'b0;
        end

        if (load)
        begin
            valid_next = 1'b1;
            char_next  = (step_reg < {2'd0, job.ncode}) ? alpha_char(idx) : PAD_CHAR;
            last_next  = job.is_end && final_step;
            step_next  = final_step ? 4'd0 : step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload, no reset needed
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign char_valid = valid_reg;
    assign code_char  = char_reg;
    assign last_char  = last_reg;

endmodule

`default_nettype wire

@@ hw/rtl/base32_stream_encoder_core.sv @@
// Streaming base32 (RFC 4648) encoder. Each input beat carries at most one
// byte and an end-of-message flag; each output beat is one ASCII character,
// with last_char set on the final character of a closed message. The front
// end takes one input beat per cycle while its job queue (QUEUE_DEPTH jobs)
// has room; the back end emits one character per cycle from the queue while
// char_ready accepts it, so a byte yields 1 or 2 characters (1.6 on average)
// and a closing beat up to 8 characters including padding. Sustained
// throughput is set by the one-character-per-cycle output register. An empty
// message, or a bare end with nothing pending, produces no characters.
// Depends on b32e_pkg, b32e_front, b32e_fifo and b32e_back.
`default_nettype none

module base32_stream_encoder_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    item_valid,
    output logic                         item_ready,
    input  wire logic [7:0]              data_byte,
    input  wire logic                    has_byte,
    input  wire logic                    end_of_message,
    output logic                         char_valid,
    input  wire logic                    char_ready,
    output logic [b32e_pkg::CHAR_W-1:0]  code_char,
    output logic                         last_char
);
    import b32e_pkg::*;

    job_t wr_job;
    job_t rd_job;
    logic job_push;
    logic job_pop;
    logic q_full;
    logic q_empty;
    logic accept;

    assign item_ready = !q_full;
    assign accept     = item_valid && item_ready;

    b32e_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .job            (wr_job),
        .job_push       (job_push)
    );

    b32e_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (job_push),
        .wr_job (wr_job),
        .pop    (job_pop),
        .rd_job (rd_job),
        .full   (q_full),
        .empty  (q_empty)
    );

    b32e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (rd_job),
        .job_avail  (!q_empty),
        .job_pop    (job_pop),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .code_char  (code_char),
        .last_char  (last_char)
    );

endmodule

`default_nettype wire
